/* rtl/apll_pkg.sv */
// ----------------------------------------------------------------------------
// apll_pkg
// Shared constants for the pooled linked list: pool size, link encoding,
// request codes and result status codes.
// ----------------------------------------------------------------------------
package apll_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = 7;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;

    localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

    localparam logic [FUNC_W-1:0] FN_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POS   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ELEMENT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

endpackage

/* rtl/apll_ram.sv */
// ----------------------------------------------------------------------------
// apll_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module apll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/array_pool_linked_list.sv */
// ----------------------------------------------------------------------------
// array_pool_linked_list
// Singly linked list in a fixed node pool, nodes taken in order and never
// freed. Inserts at front, end or position, and reads out the whole list.
//
// channel   dir  tdata                          tuser        tlast
// s_*       in   [31:0] value, [39:32] position [1:0] func   -
// m_*       out  [31:0] element                 [2:0] status last
//
// insert at front and error results pass through S_EMIT to the output register
// insert at end or position: walks the links in S_WALK, then S_SPLICE (mid-list) and S_EMIT
// read-out: one element per cycle while m_tready allows, one link memory read per element
// pointer walk is bound by the registered read of the link memory
// no clearing pass after reset; s_tready is low while an item is at work
// m_tvalid/m_tdata hold under m_tready low; the read-out walk pauses meanwhile
// ----------------------------------------------------------------------------
module array_pool_linked_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [39:32]
    input  logic [1:0]  s_tuser,   // func [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // element [31:0]
    output logic [2:0]  m_tuser,   // status [2:0]
    output logic        m_tlast
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_SPLICE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_TAIL = 2'd1;
    localparam logic [1:0] MODE_POS  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [1:0]                          mode_reg, mode_next;
    logic [apll_pkg::LINK_W-1:0]         cur_reg, cur_next;
    logic [apll_pkg::LINK_W-1:0]         new_reg, new_next;
    logic [apll_pkg::LINK_W-1:0]         head_reg, head_next;
    logic [apll_pkg::LINK_W-1:0]         fill_reg, fill_next;
    logic [apll_pkg::LINK_W-1:0]         nx_reg, nx_next;
    logic [apll_pkg::POS_W-1:0]          steps_reg, steps_next;
    logic [apll_pkg::STATUS_W-1:0]       res_reg, res_next;

    logic                                m_tvalid_reg;
    logic [apll_pkg::DATA_W-1:0]         m_tdata_reg;
    logic [apll_pkg::STATUS_W-1:0]       m_tuser_reg;
    logic                                m_tlast_reg;

    logic                                out_free;
    logic                                out_load;
    logic [apll_pkg::STATUS_W-1:0]       out_status;
    logic [apll_pkg::DATA_W-1:0]         out_elem;
    logic                                out_last;

    logic                                lw_en;
    logic [apll_pkg::IDX_W-1:0]          lw_addr;
    logic [apll_pkg::LINK_W-1:0]         lw_data;
    logic                                dw_en;
    logic [apll_pkg::LINK_W-1:0]         link_rd;
    logic [apll_pkg::DATA_W-1:0]         data_rd;
    logic [apll_pkg::LINK_W-1:0]         nx;

    logic [apll_pkg::FUNC_W-1:0]         in_func;
    logic [apll_pkg::DATA_W-1:0]         in_value;
    logic [apll_pkg::POS_W-1:0]          in_pos;
    logic                                pool_full;
    logic                                head_null;
    logic                                is_front;
    logic                                is_badpos;

    assign in_func  = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_pos   = s_tdata[39:32];

    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pool_full = (fill_reg >= apll_pkg::LINK_W'(apll_pkg::POOL_SIZE));
    assign head_null = (head_reg == apll_pkg::NULL_LINK);
    assign is_front  = (in_func == apll_pkg::FN_FRONT)
                    || ((in_func == apll_pkg::FN_POS) && (in_pos == 8'd1));
    assign is_badpos = (in_func == apll_pkg::FN_POS) && (in_pos == 8'd0);

    // links outside the pool read as null
    assign nx = (link_rd >= apll_pkg::LINK_W'(apll_pkg::POOL_SIZE))
              ? apll_pkg::NULL_LINK : link_rd;

    apll_ram #(
        .WIDTH (apll_pkg::DATA_W),
        .DEPTH (apll_pkg::POOL_SIZE)
    ) u_data_ram (
        .clk   (clk),
        .we    (dw_en),
        .waddr (fill_reg[apll_pkg::IDX_W-1:0]),
        .wdata (in_value),
        .raddr (cur_next[apll_pkg::IDX_W-1:0]),
        .rdata (data_rd)
    );

    apll_ram #(
        .WIDTH (apll_pkg::LINK_W),
        .DEPTH (apll_pkg::POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (lw_en),
        .waddr (lw_addr),
        .wdata (lw_data),
        .raddr (cur_next[apll_pkg::IDX_W-1:0]),
        .rdata (link_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        new_next   = new_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        nx_next    = nx_reg;
        steps_next = steps_reg;
        res_next   = res_reg;
        lw_en      = 1'b0;
        lw_addr    = new_reg[apll_pkg::IDX_W-1:0];
        lw_data    = apll_pkg::NULL_LINK;
        dw_en      = 1'b0;
        out_load   = 1'b0;
        out_status = res_reg;
        out_elem   = '0;
        out_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_func == apll_pkg::FN_READ)
                    begin
                        if (head_null)
                        begin
                            res_next   = apll_pkg::ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            mode_next  = MODE_READ;
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        priority if (is_badpos)
                        begin
                            res_next   = apll_pkg::ST_BADPOS;
                            state_next = S_EMIT;
                        end
                        else if (pool_full)
                        begin
                            res_next   = apll_pkg::ST_FULL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            // take the next pool node
                            dw_en     = 1'b1;
                            lw_en     = 1'b1;
                            lw_addr   = fill_reg[apll_pkg::IDX_W-1:0];
                            lw_data   = is_front ? head_reg : apll_pkg::NULL_LINK;
                            fill_next = fill_reg + 7'd1;
                            new_next  = fill_reg;
                            if (is_front)
                            begin
                                head_next  = fill_reg;
                                res_next   = apll_pkg::ST_OK;
                                state_next = S_EMIT;
                            end
                            else if (head_null)
                            begin
                                head_next  = fill_reg;
                                res_next   = (in_func == apll_pkg::FN_POS)
                                           ? apll_pkg::ST_APPENDED : apll_pkg::ST_OK;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                mode_next  = (in_func == apll_pkg::FN_END)
                                           ? MODE_TAIL : MODE_POS;
                                steps_next = in_pos - 8'd2;
                                state_next = S_WALK;
                            end
                        end
                    end
                end
            end

            S_WALK:
            begin
                unique case (mode_reg)
                    MODE_READ:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            out_status = apll_pkg::ST_ELEMENT;
                            out_elem   = data_rd;
                            out_last   = (nx == apll_pkg::NULL_LINK);
                            if (nx == apll_pkg::NULL_LINK)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cur_next = nx;
                            end
                        end
                    end
                    MODE_TAIL:
                    begin
                        if (nx == apll_pkg::NULL_LINK)
                        begin
                            lw_en      = 1'b1;
                            lw_addr    = cur_reg[apll_pkg::IDX_W-1:0];
                            lw_data    = new_reg;
                            res_next   = apll_pkg::ST_OK;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cur_next = nx;
                        end
                    end
                    MODE_POS:
                    begin
                        if (steps_reg == 8'd0)
                        begin
                            // splice after cur, new node takes over its link
                            lw_en      = 1'b1;
                            lw_addr    = cur_reg[apll_pkg::IDX_W-1:0];
                            lw_data    = new_reg;
                            nx_next    = nx;
                            state_next = S_SPLICE;
                        end
                        else if (nx == apll_pkg::NULL_LINK)
                        begin
                            // ran off the list: append after the tail
                            lw_en      = 1'b1;
                            lw_addr    = cur_reg[apll_pkg::IDX_W-1:0];
                            lw_data    = new_reg;
                            res_next   = apll_pkg::ST_APPENDED;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cur_next   = nx;
                            steps_next = steps_reg - 8'd1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SPLICE:
            begin
                lw_en      = 1'b1;
                lw_addr    = new_reg[apll_pkg::IDX_W-1:0];
                lw_data    = nx_reg;
                res_next   = apll_pkg::ST_OK;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_READ;
            cur_reg      <= apll_pkg::NULL_LINK;
            head_reg     <= apll_pkg::NULL_LINK;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        new_reg   <= new_next;
        nx_reg    <= nx_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            m_tdata_reg <= out_elem;
            m_tuser_reg <= out_status;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
